// ===== rtl/rob_pkg.sv =====
// Package for the reorder buffer commit block: field widths, entry kinds,
// input/result transfer structs and the stored entry layout. No dependencies.
`default_nettype none

package rob_pkg;

  localparam int unsigned TAG_W  = 5;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned DEST_W = 5;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned VAL_W  = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_REG    = 2'd0,
    KIND_BRANCH = 2'd1,
    KIND_STORE  = 2'd2,
    KIND_EXIT   = 2'd3
  } kind_e;

  typedef struct packed {
    logic              dispatch_valid;
    logic [KIND_W-1:0] dispatch_kind;
    logic [DEST_W-1:0] dispatch_dest;
    logic [ADDR_W-1:0] dispatch_instr_addr;
    logic [ADDR_W-1:0] dispatch_jump_addr;
    logic              rs_valid;
    logic [TAG_W-1:0]  rs_tag;
    logic [VAL_W-1:0]  rs_value;
    logic              lsb_valid;
    logic [TAG_W-1:0]  lsb_tag;
    logic [VAL_W-1:0]  lsb_value;
  } rob_in_t;

  typedef struct packed {
    logic [TAG_W-1:0]  dispatch_tag;
    logic              overflow;
    logic              commit_valid;
    logic [KIND_W-1:0] commit_kind;
    logic [DEST_W-1:0] commit_dest;
    logic [TAG_W-1:0]  commit_tag;
    logic [VAL_W-1:0]  commit_value;
    logic [ADDR_W-1:0] branch_addr;
    logic              branch_correct;
    logic              redirect_valid;
    logic [ADDR_W-1:0] redirect_pc;
    logic              flushing;
  } rob_out_t;

  // Fields written once at dispatch and read back at retire.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DEST_W-1:0] dest;
    logic [ADDR_W-1:0] instr_addr;
    logic [ADDR_W-1:0] jump_addr;
  } rob_entry_t;

endpackage

`default_nettype wire

// ===== rtl/rob_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// A write to the address being read in the same cycle is passed through.
`default_nettype none

module rob_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // write-first: return the new data on an address match
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/reorder_buffer_commit.sv =====
// Reorder buffer with in-order commit, one step per accepted transfer.
// Path: an input transfer is captured in the input register, and the step taken from it
// loads the result register, which drives the result channel.
// Throughput: one transfer per cycle; a stalled result holds the input register,
// which then stalls the input. Reset clears head, tail, count, flush flag and done
// bits at once; entry stores are RAMs and are not cleared (never read before written).
`default_nettype none

module reorder_buffer_commit #(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input channel
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire rob_pkg::rob_in_t  in_data_i,
  // result channel
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      rob_pkg::rob_out_t out_data_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned ENT_W = $bits(rob_pkg::rob_entry_t);

  // ---------------------------------------------------------------------------
  // Input register and step handshake
  // ---------------------------------------------------------------------------
  logic             in_vld_q, in_vld_d;
  rob_pkg::rob_in_t in_q;
  logic             out_vld_q, out_vld_d;
  rob_pkg::rob_out_t out_q;
  rob_pkg::rob_out_t res_d;

  logic in_xfer;
  logic out_free;
  logic fire;   // one buffer step happens at this edge

  assign out_free   = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !fire;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_xfer || (in_vld_q && !fire);
  assign out_vld_d  = fire || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Buffer control state
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             flush_q, flush_d;
  logic [DEPTH-1:0] done_q, done_d;
  // which writeback port last wrote each slot's value (1: load/store)
  logic [DEPTH-1:0] sel_q, sel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      flush_q <= 1'b0;
      done_q  <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      flush_q <= flush_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q <= sel_d;
  end

  // ---------------------------------------------------------------------------
  // Entry stores: dispatch fields, plus one value store per writeback port.
  // All are read at the next head so the head entry is ready at step time.
  // ---------------------------------------------------------------------------
  logic                  ent_we;
  logic                  rs_we;
  logic                  lsb_we;
  logic [IDX_W-1:0]      rs_idx;
  logic [IDX_W-1:0]      lsb_idx;
  rob_pkg::rob_entry_t   ent_wdata;
  rob_pkg::rob_entry_t   head_ent;
  logic [ENT_W-1:0]      head_ent_raw;
  logic [DATA_WIDTH-1:0] head_rs_val;
  logic [DATA_WIDTH-1:0] head_lsb_val;

  assign rs_idx  = IDX_W'(in_q.rs_tag);
  assign lsb_idx = IDX_W'(in_q.lsb_tag);

  assign ent_wdata.kind       = in_q.dispatch_kind;
  assign ent_wdata.dest       = in_q.dispatch_dest;
  assign ent_wdata.instr_addr = in_q.dispatch_instr_addr;
  assign ent_wdata.jump_addr  = in_q.dispatch_jump_addr;

  rob_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (tail_q),
    .wdata_i (ent_wdata),
    .raddr_i (head_d),
    .rdata_o (head_ent_raw)
  );

  assign head_ent = rob_pkg::rob_entry_t'(head_ent_raw);

  rob_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_rs_val_ram (
    .clk_i   (clk_i),
    .we_i    (rs_we),
    .waddr_i (rs_idx),
    .wdata_i (DATA_WIDTH'(in_q.rs_value)),
    .raddr_i (head_d),
    .rdata_o (head_rs_val)
  );

  rob_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_lsb_val_ram (
    .clk_i   (clk_i),
    .we_i    (lsb_we),
    .waddr_i (lsb_idx),
    .wdata_i (DATA_WIDTH'(in_q.lsb_value)),
    .raddr_i (head_d),
    .rdata_o (head_lsb_val)
  );

  // ---------------------------------------------------------------------------
  // Step logic: flush, or writebacks + retire + dispatch
  // ---------------------------------------------------------------------------
  logic                  full;
  logic                  retire;
  logic                  push;
  logic                  rs_hit;
  logic                  lsb_hit;
  logic                  br_ok;
  logic [DATA_WIDTH-1:0] head_val;
  logic [IDX_W-1:0]      head_nxt;
  logic [IDX_W-1:0]      tail_nxt;

  assign full     = (count_q == CNT_W'(DEPTH));
  assign head_val = sel_q[head_q] ? head_lsb_val : head_rs_val;
  assign retire   = !flush_q && (count_q != '0) && done_q[head_q];
  assign push     = !flush_q && in_q.dispatch_valid && !full;
  // tags beyond the buffer are dropped
  assign rs_hit   = !flush_q && in_q.rs_valid && (32'(in_q.rs_tag) < 32'(DEPTH));
  assign lsb_hit  = !flush_q && in_q.lsb_valid && (32'(in_q.lsb_tag) < 32'(DEPTH));
  assign br_ok    = (head_val[0] == head_ent.jump_addr[0]);
  assign head_nxt = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_nxt = (tail_q == IDX_W'(DEPTH - 1)) ? '0 : tail_q + 1'b1;

  assign ent_we = fire && push;
  assign rs_we  = fire && rs_hit;
  assign lsb_we = fire && lsb_hit;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    flush_d = flush_q;
    done_d  = done_q;
    sel_d   = sel_q;
    res_d   = '0;
    res_d.dispatch_tag = rob_pkg::TAG_W'(tail_q);

    if (flush_q) begin
      // drop everything and empty the buffer
      res_d.flushing = 1'b1;
      if (fire) begin
        head_d  = '0;
        tail_d  = '0;
        count_d = '0;
        flush_d = 1'b0;
        done_d  = '0;
      end
    end else begin
      if (retire) begin
        res_d.commit_valid = 1'b1;
        res_d.commit_kind  = head_ent.kind;
        res_d.commit_tag   = rob_pkg::TAG_W'(head_q);
        case (head_ent.kind)
          rob_pkg::KIND_REG: begin
            res_d.commit_dest  = head_ent.dest;
            res_d.commit_value = head_val[rob_pkg::VAL_W-1:0];
          end
          rob_pkg::KIND_BRANCH: begin
            res_d.branch_addr    = head_ent.instr_addr;
            res_d.branch_correct = br_ok;
            if (!br_ok) begin
              res_d.redirect_valid = 1'b1;
              res_d.redirect_pc    = {head_ent.jump_addr[rob_pkg::ADDR_W-1:1], 1'b0};
            end
          end
          default: begin
          end
        endcase
      end
      res_d.overflow = in_q.dispatch_valid && full;

      if (fire) begin
        // writebacks first, load/store port last so it wins a shared tag
        if (rs_hit) begin
          done_d[rs_idx] = 1'b1;
          sel_d[rs_idx]  = 1'b0;
        end
        if (lsb_hit) begin
          done_d[lsb_idx] = 1'b1;
          sel_d[lsb_idx]  = 1'b1;
        end
        if (retire) begin
          head_d = head_nxt;
          if ((head_ent.kind == rob_pkg::KIND_BRANCH) && !br_ok) begin
            flush_d = 1'b1;
          end
        end
        // a dispatch overrides a writeback to the same slot
        if (push) begin
          done_d[tail_q] = 1'b0;
          tail_d         = tail_nxt;
        end
        case ({retire, push})
          2'b10:   count_d = count_q - 1'b1;
          2'b01:   count_d = count_q + 1'b1;
          default: count_d = count_q;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic [CNT_W:0] hc_sum;
  logic [CNT_W:0] hc_wrap;

  assign hc_sum  = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(count_q);
  assign hc_wrap = (hc_sum >= (CNT_W + 1)'(DEPTH)) ? hc_sum - (CNT_W + 1)'(DEPTH) : hc_sum;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  a_ptr_consistent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q == IDX_W'(hc_wrap))
    else $error("tail does not match head plus count");

  a_redirect_flush : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res_d.redirect_valid |=> flush_q)
    else $error("mispredict did not schedule a flush");

  a_flush_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && flush_q |=> (count_q == '0) && (head_q == '0) && (done_q == '0) && !flush_q)
    else $error("flush step left the buffer non-empty");

endmodule

`default_nettype wire
